// ===== rtl/core/missing_tooth_wheel_sync_core_assert.svh =====
// Assertion macros shared by the core.
`ifndef MISSING_TOOTH_WHEEL_SYNC_CORE_ASSERT_SVH
`define MISSING_TOOTH_WHEEL_SYNC_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MTWS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MTWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtws_pkg.sv =====
package mtws_pkg;

  localparam int TEETH        = 36;
  localparam int COIL_DRIVERS = 8;

  localparam int TOOTH_W = 6;
  localparam int IDX_W   = $clog2(TEETH);

  typedef logic [TOOTH_W-1:0] tooth_t;
  typedef logic [TOOTH_W:0]   tooth_ext_t;
  typedef logic [IDX_W-1:0]   sched_idx_t;

  localparam tooth_t     LAST_TOOTH = tooth_t'(TEETH - 1);
  localparam tooth_ext_t TEETH_NUM  = tooth_ext_t'(TEETH);
  localparam logic [7:0] COIL_MASK  = 8'(((1 << COIL_DRIVERS) - 1) & 8'hFF);

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // item kinds
  localparam logic [1:0] KIND_EDGE     = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_WRITE    = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECALC_TOOTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 2'd1;

  localparam logic [7:0] OVERFLOW_LIMIT_RST = 8'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] capture_count;
    logic [5:0]  entry_index;
    logic [7:0]  fire_mask_in;
    logic [15:0] fire_delay_in;
    logic [7:0]  charge_mask_in;
    logic [15:0] charge_delay_in;
  } in_item_t;

  typedef struct packed {
    logic        synchronized;
    logic        engine_running;
    logic [5:0]  tooth_number;
    logic [31:0] tooth_period;
    logic [31:0] revolution_period;
    logic [15:0] sync_attempts;
    logic [7:0]  fire_mask;
    logic [15:0] fire_delay;
    logic [7:0]  charge_mask;
    logic [15:0] charge_delay;
    logic        recalc_request;
    logic        all_coils_off;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  fmask;
    logic [15:0] fdelay;
    logic [7:0]  cmask;
    logic [15:0] cdelay;
  } sched_entry_t;

  typedef struct packed {
    logic         rd_en;
    sched_idx_t   rd_addr;
    logic         wr_en;
    sched_idx_t   wr_addr;
    sched_entry_t wr_data;
  } sched_req_t;

  // state snapshot after one item, minus the schedule lookup
  typedef struct packed {
    logic        synchronized;
    logic        engine_running;
    tooth_t      tooth_number;
    logic [31:0] tooth_period;
    logic [31:0] revolution_period;
    logic [15:0] sync_attempts;
    logic        recalc_request;
    logic        all_coils_off;
  } status_t;

endpackage

// ===== rtl/core/missing_tooth_wheel_sync_core.sv =====
// Missing-tooth crank wheel decoder. Takes one item per clock while in_stall is low
// (tooth edge, timer overflow tick or schedule table write) and returns exactly one
// result per item, in order, after it passes the lookup stage and the output queue. The
// per-tooth coil schedule lives in a 36 x 48-bit synchronous RAM whose read data arrives
// in the cycle after the edge that selects the tooth; the scalar wheel state is updated in the
// accept cycle, so back-to-back items never wait on each other. A two-entry output
// queue lets input keep flowing while a result waits; in_stall rises only when the
// queue and the lookup stage are both full. Per-entry valid bits clear the table
// at reset, so no clearing pass is needed. Configuration writes are always ready.
module missing_tooth_wheel_sync_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mtws_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mtws_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  `include "missing_tooth_wheel_sync_core_assert.svh"

  mtws_pkg::tooth_t recalc_tooth;
  logic [7:0]       overflow_limit;

  logic                   in_accept;
  mtws_pkg::status_t      status;
  mtws_pkg::sched_req_t   sched_req;
  mtws_pkg::sched_entry_t rd_entry;
  logic                   rd_hit;

  logic                s1_valid;
  mtws_pkg::status_t   s1_status;
  logic                s1_lookup;
  logic                q_full;
  logic                s1_move;
  mtws_pkg::out_item_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recalc_tooth   <= '0;
      overflow_limit <= mtws_pkg::OVERFLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtws_pkg::REG_RECALC_TOOTH:   recalc_tooth   <= cfg_data[mtws_pkg::TOOTH_W-1:0];
        mtws_pkg::REG_OVERFLOW_LIMIT: overflow_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_move   = s1_valid && !q_full;
  assign in_stall  = s1_valid && q_full;
  assign in_accept = in_valid && !in_stall;

  mtws_track u_track (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .item           (in_data),
    .recalc_tooth   (recalc_tooth),
    .overflow_limit (overflow_limit),
    .status         (status),
    .sched_req      (sched_req)
  );

  mtws_sched u_sched (
    .clk      (clk),
    .rst      (rst),
    .req      (sched_req),
    .rd_entry (rd_entry),
    .rd_hit   (rd_hit)
  );

  // lookup stage: RAM read data arrives alongside the registered status
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_lookup <= 1'b0;
    end else if (in_accept) begin
      s1_valid  <= 1'b1;
      s1_lookup <= sched_req.rd_en;
    end else if (s1_move) begin
      s1_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status <= status;
    end
  end

  always_comb begin
    result.synchronized      = s1_status.synchronized;
    result.engine_running    = s1_status.engine_running;
    result.tooth_number      = s1_status.tooth_number;
    result.tooth_period      = s1_status.tooth_period;
    result.revolution_period = s1_status.revolution_period;
    result.sync_attempts     = s1_status.sync_attempts;
    result.recalc_request    = s1_status.recalc_request;
    result.all_coils_off     = s1_status.all_coils_off;
    result.fire_mask         = '0;
    result.fire_delay        = '0;
    result.charge_mask       = '0;
    result.charge_delay      = '0;
    if (s1_lookup && rd_hit) begin
      if (rd_entry.fmask != 8'd0) begin
        result.fire_mask  = rd_entry.fmask;
        result.fire_delay = rd_entry.fdelay;
      end
      if (rd_entry.cmask != 8'd0) begin
        result.charge_mask  = rd_entry.cmask;
        result.charge_delay = rd_entry.cdelay;
      end
    end
  end

  mtws_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_move),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MTWS_ASSERT_NOW(a_fire_needs_sync, clk, rst,
    out_valid && (out_data.fire_mask != 8'd0 || out_data.charge_mask != 8'd0),
    out_data.synchronized, "coil scheduled while not synchronized")
  `MTWS_ASSERT_NOW(a_cut_clears_state, clk, rst,
    out_valid && out_data.all_coils_off,
    !out_data.engine_running && !out_data.synchronized && out_data.sync_attempts == 16'd0,
    "coil cut without stopped state")
  `MTWS_ASSERT_NOW(a_tooth_in_range, clk, rst,
    out_valid, {1'b0, out_data.tooth_number} < mtws_pkg::TEETH_NUM,
    "tooth number beyond wheel")
  `MTWS_ASSERT_NEXT(a_stall_holds_stage, clk, rst,
    in_stall, s1_valid, "lookup stage dropped while input stalled")

endmodule

// ===== rtl/core/mtws_sched.sv =====
module mtws_sched (
  input  logic                  clk,
  input  logic                  rst,
  input  mtws_pkg::sched_req_t  req,
  output mtws_pkg::sched_entry_t rd_entry,
  output logic                  rd_hit
);

  mtws_pkg::sched_entry_t mem [mtws_pkg::TEETH];
  logic [mtws_pkg::TEETH-1:0] written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_addr];
    end
  end

  // entries never written read back as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= written[req.rd_addr];
      end
    end
  end

endmodule

// ===== rtl/core/mtws_track.sv =====
module mtws_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  mtws_pkg::in_item_t   item,
  input  mtws_pkg::tooth_t     recalc_tooth,
  input  logic [7:0]           overflow_limit,
  output mtws_pkg::status_t    status,
  output mtws_pkg::sched_req_t sched_req
);

  mtws_pkg::tooth_t tooth_counter, tooth_counter_next;
  logic [31:0] last_period, last_period_next;
  logic [31:0] rev_acc, rev_acc_next;
  logic [31:0] last_rev, last_rev_next;
  logic [15:0] ovf_counter, ovf_counter_next;
  logic        sync_flag, sync_flag_next;
  logic        running_flag, running_flag_next;
  logic [15:0] attempts, attempts_next;

  logic [31:0] period_full;
  logic [31:0] period_half;
  logic [32:0] bound;
  logic        gap;
  mtws_pkg::tooth_t tooth_inc;
  logic [15:0] ovf_inc;
  logic [15:0] attempts_inc;
  logic        coils_off;

  assign period_full  = {ovf_counter, item.capture_count};
  assign period_half  = {1'b0, period_full[31:1]};
  assign bound        = {1'b0, last_period} + {2'b00, last_period[31:1]};
  assign gap          = {1'b0, period_full} > bound;
  assign tooth_inc    = tooth_counter + mtws_pkg::tooth_t'(1);
  assign ovf_inc      = (ovf_counter == mtws_pkg::CNT_MAX) ? ovf_counter : ovf_counter + 16'd1;
  assign attempts_inc = (attempts == mtws_pkg::CNT_MAX) ? attempts : attempts + 16'd1;

  always_comb begin
    tooth_counter_next = tooth_counter;
    last_period_next   = last_period;
    rev_acc_next       = rev_acc;
    last_rev_next      = last_rev;
    ovf_counter_next   = ovf_counter;
    sync_flag_next     = sync_flag;
    running_flag_next  = running_flag;
    attempts_next      = attempts;
    coils_off          = 1'b0;
    sched_req          = '0;

    case (item.kind)
      mtws_pkg::KIND_EDGE: begin
        if (gap) begin
          last_period_next = period_half;
          rev_acc_next     = period_half;
          if (tooth_counter != mtws_pkg::LAST_TOOTH) begin
            sync_flag_next = 1'b0;
            attempts_next  = attempts_inc;
          end else begin
            sync_flag_next    = 1'b1;
            last_rev_next     = rev_acc + period_half;
            running_flag_next = 1'b1;
          end
          tooth_counter_next = mtws_pkg::tooth_t'(1);
        end else begin
          last_period_next = period_full;
          if (tooth_inc > mtws_pkg::LAST_TOOTH) begin
            sync_flag_next     = 1'b0;
            rev_acc_next       = period_full;
            attempts_next      = attempts_inc;
            tooth_counter_next = '0;
          end else begin
            rev_acc_next       = rev_acc + period_full;
            tooth_counter_next = tooth_inc;
          end
        end
        ovf_counter_next = '0;
        // look up the new tooth's schedule only when it will be used
        sched_req.rd_en   = sync_flag_next &&
                            ({1'b0, tooth_counter_next} < mtws_pkg::TEETH_NUM);
        sched_req.rd_addr = tooth_counter_next[mtws_pkg::IDX_W-1:0];
      end
      mtws_pkg::KIND_OVERFLOW: begin
        ovf_counter_next = ovf_inc;
        if (ovf_inc > {8'd0, overflow_limit}) begin
          coils_off         = 1'b1;
          running_flag_next = 1'b0;
          sync_flag_next    = 1'b0;
          attempts_next     = '0;
        end
      end
      mtws_pkg::KIND_WRITE: begin
        sched_req.wr_en          = {1'b0, item.entry_index} < mtws_pkg::TEETH_NUM;
        sched_req.wr_addr        = item.entry_index[mtws_pkg::IDX_W-1:0];
        sched_req.wr_data.fmask  = item.fire_mask_in & mtws_pkg::COIL_MASK;
        sched_req.wr_data.fdelay = item.fire_delay_in;
        sched_req.wr_data.cmask  = item.charge_mask_in & mtws_pkg::COIL_MASK;
        sched_req.wr_data.cdelay = item.charge_delay_in;
      end
      default: begin
      end
    endcase

    if (!accept) begin
      sched_req.rd_en = 1'b0;
      sched_req.wr_en = 1'b0;
    end

    status.synchronized      = sync_flag_next;
    status.engine_running    = running_flag_next;
    status.tooth_number      = tooth_counter_next;
    status.tooth_period      = last_period_next;
    status.revolution_period = last_rev_next;
    status.sync_attempts     = attempts_next;
    status.recalc_request    = (item.kind == mtws_pkg::KIND_EDGE) &&
                               (tooth_counter_next == recalc_tooth);
    status.all_coils_off     = coils_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_counter <= '0;
      last_period   <= '0;
      rev_acc       <= '0;
      last_rev      <= '0;
      ovf_counter   <= '0;
      sync_flag     <= 1'b0;
      running_flag  <= 1'b0;
      attempts      <= '0;
    end else if (accept) begin
      tooth_counter <= tooth_counter_next;
      last_period   <= last_period_next;
      rev_acc       <= rev_acc_next;
      last_rev      <= last_rev_next;
      ovf_counter   <= ovf_counter_next;
      sync_flag     <= sync_flag_next;
      running_flag  <= running_flag_next;
      attempts      <= attempts_next;
    end
  end

endmodule

// ===== rtl/core/mtws_outq.sv =====
module mtws_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mtws_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output mtws_pkg::out_item_t out_data
);

  mtws_pkg::out_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== verif/missing_tooth_wheel_sync_checker.sv =====
`timescale 1ns / 1ps
module missing_tooth_wheel_sync_checker
  import mtws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int REPORT_CAP = 200;

  // wheel state as the decoder should hold it
  tooth_t       wheel_tooth;
  logic [31:0]  wheel_last_period;
  logic [31:0]  rev_accum;
  logic [31:0]  rev_last;
  logic [15:0]  ovf_count;
  logic         in_sync;
  logic         running;
  logic [15:0]  attempts;
  sched_entry_t sched_table [TEETH];

  tooth_t       cfg_recalc_tooth;
  logic [7:0]   cfg_ovf_limit;

  out_item_t    expected_results [$];
  out_item_t    want;
  int           errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
  end

  function automatic void reset_wheel();
    wheel_tooth       = '0;
    wheel_last_period = '0;
    rev_accum         = '0;
    rev_last          = '0;
    ovf_count         = '0;
    in_sync           = 1'b0;
    running           = 1'b0;
    attempts          = '0;
    foreach (sched_table[i]) sched_table[i] = '0;
    cfg_recalc_tooth  = '0;
    cfg_ovf_limit     = OVERFLOW_LIMIT_RST;
  endfunction

  function automatic void bump_attempts();
    if (attempts != CNT_MAX) attempts = attempts + 16'd1;
  endfunction

  function automatic out_item_t advance_wheel(input in_item_t it);
    out_item_t    r;
    logic [31:0]  period;
    logic [32:0]  bound;
    tooth_t       nxt;
    sched_entry_t e;
    r = '0;
    case (it.kind)
      KIND_EDGE: begin
        period = {ovf_count, 16'h0000} + {16'h0000, it.capture_count};
        // 33-bit bound so 1.5x of a large period cannot wrap
        bound  = {1'b0, wheel_last_period} + {2'b00, wheel_last_period[31:1]};
        if ({1'b0, period} > bound) begin
          period = period >> 1;
          if (wheel_tooth != LAST_TOOTH) begin
            in_sync   = 1'b0;
            rev_accum = period;
            bump_attempts();
          end else begin
            in_sync   = 1'b1;
            rev_last  = rev_accum + period;
            rev_accum = period;
            running   = 1'b1;
          end
          wheel_tooth = tooth_t'(1);
        end else begin
          nxt = wheel_tooth + tooth_t'(1);
          if (nxt > LAST_TOOTH) begin
            in_sync   = 1'b0;
            rev_accum = period;
            bump_attempts();
            nxt = '0;
          end else begin
            rev_accum = rev_accum + period;
          end
          wheel_tooth = nxt;
        end
        if (in_sync && wheel_tooth < TEETH) begin
          e = sched_table[wheel_tooth];
          if (e.fmask != 0) begin
            r.fire_mask  = e.fmask;
            r.fire_delay = e.fdelay;
          end
          if (e.cmask != 0) begin
            r.charge_mask  = e.cmask;
            r.charge_delay = e.cdelay;
          end
        end
        ovf_count         = '0;
        wheel_last_period = period;
        r.recalc_request  = (wheel_tooth == cfg_recalc_tooth);
      end
      KIND_OVERFLOW: begin
        if (ovf_count != CNT_MAX) ovf_count = ovf_count + 16'd1;
        if (ovf_count > {8'h00, cfg_ovf_limit}) begin
          r.all_coils_off = 1'b1;
          running         = 1'b0;
          in_sync         = 1'b0;
          attempts        = '0;
        end
      end
      KIND_WRITE: begin
        if (it.entry_index < TEETH) begin
          sched_table[it.entry_index].fmask  = it.fire_mask_in & COIL_MASK;
          sched_table[it.entry_index].fdelay = it.fire_delay_in;
          sched_table[it.entry_index].cmask  = it.charge_mask_in & COIL_MASK;
          sched_table[it.entry_index].cdelay = it.charge_delay_in;
        end
      end
      default: begin
      end
    endcase
    r.synchronized      = in_sync;
    r.engine_running    = running;
    r.tooth_number      = wheel_tooth;
    r.tooth_period      = wheel_last_period;
    r.revolution_period = rev_last;
    r.sync_attempts     = attempts;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (errors < REPORT_CAP)
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_wheel();
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (errors < REPORT_CAP) $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("synchronized", 32'(want.synchronized), 32'(out_data.synchronized));
          check_field("engine_running", 32'(want.engine_running),
                      32'(out_data.engine_running));
          check_field("tooth_number", 32'(want.tooth_number), 32'(out_data.tooth_number));
          check_field("tooth_period", want.tooth_period, out_data.tooth_period);
          check_field("revolution_period", want.revolution_period,
                      out_data.revolution_period);
          check_field("sync_attempts", 32'(want.sync_attempts), 32'(out_data.sync_attempts));
          check_field("fire_mask", 32'(want.fire_mask), 32'(out_data.fire_mask));
          check_field("fire_delay", 32'(want.fire_delay), 32'(out_data.fire_delay));
          check_field("charge_mask", 32'(want.charge_mask), 32'(out_data.charge_mask));
          check_field("charge_delay", 32'(want.charge_delay), 32'(out_data.charge_delay));
          check_field("recalc_request", 32'(want.recalc_request),
                      32'(out_data.recalc_request));
          check_field("all_coils_off", 32'(want.all_coils_off),
                      32'(out_data.all_coils_off));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RECALC_TOOTH:   cfg_recalc_tooth = cfg_data[5:0];
          REG_OVERFLOW_LIMIT: cfg_ovf_limit    = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(advance_wheel(in_data));
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

// ===== verif/missing_tooth_wheel_sync_core_tb.sv =====
`timescale 1ns / 1ps
module missing_tooth_wheel_sync_core_tb;
  import mtws_pkg::*;

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 140;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   fail_count;
  int                   pending;

  int       items_sent = 0;
  int       burst_left = 0;
  bit       steady = 1'b0;
  int       hold_token = 0;
  int       hold_taken = 0;
  int       hold_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;
  int       idle_cycles = 0;

  missing_tooth_wheel_sync_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  missing_tooth_wheel_sync_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stall modes, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_token) begin
      hold_taken = hold_token;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= rx_left[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.kind            = 2'($urandom_range(0, 3));
    it.capture_count   = 16'($urandom);
    it.entry_index     = 6'($urandom);
    it.fire_mask_in    = 8'($urandom);
    it.fire_delay_in   = 16'($urandom);
    it.charge_mask_in  = 8'($urandom);
    it.charge_delay_in = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t edge_item(input logic [15:0] cap);
    in_item_t it;
    it               = rand_item();
    it.kind          = KIND_EDGE;
    it.capture_count = cap;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it      = rand_item();
    it.kind = KIND_OVERFLOW;
    return it;
  endfunction

  function automatic in_item_t write_item(input logic [5:0] idx, input logic [7:0] fm,
                                          input logic [15:0] fd, input logic [7:0] cm,
                                          input logic [15:0] cd);
    in_item_t it;
    it.kind            = KIND_WRITE;
    it.capture_count   = 16'($urandom);
    it.entry_index     = idx;
    it.fire_mask_in    = fm;
    it.fire_delay_in   = fd;
    it.charge_mask_in  = cm;
    it.charge_delay_in = cd;
    return it;
  endfunction

  // mostly valid teeth, some out-of-range indexes, some empty masks
  function automatic in_item_t rand_write_item();
    logic [5:0] idx;
    idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(36, 63))
                                      : 6'($urandom_range(0, 35));
    return write_item(idx, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
                      16'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
                      16'($urandom));
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (!steady && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // long periods arrive as overflow ticks followed by the edge capture
  task automatic send_period(input int p);
    repeat (p >> 16) send_item(tick_item());
    send_item(edge_item(16'(p)));
  endtask

  task automatic spin_wheel(input int base, input int revs, input bit broken);
    int teeth;
    send_period(2 * base + $urandom_range(0, base / 4));
    repeat (revs) begin
      teeth = broken ? $urandom_range(31, 38) : TEETH - 2;
      repeat (teeth) begin
        send_period(base - base / 8 + $urandom_range(0, base / 4));
        if ($urandom_range(0, 29) == 0) send_item(rand_write_item());
      end
      send_period(2 * base + $urandom_range(0, base / 4));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int         phase_start;
    int         pick;
    int         base;
    logic [5:0] recalc;
    logic [7:0] limit;
    in_item_t   odd;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: register extremes, table corners, unused kind, edges and ticks
    write_reg(REG_RECALC_TOOTH, 8'hC1);
    write_reg(REG_OVERFLOW_LIMIT, 8'd2);
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    send_item(write_item(6'd0, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(write_item(6'd35, 8'h5A, 16'h1234, 8'hA5, 16'hFEDC));
    send_item(write_item(6'd36, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(write_item(6'd63, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(write_item(6'd1, 8'h00, 16'h4321, 8'h81, 16'h0000));
    odd      = rand_item();
    odd.kind = KIND_UNUSED;
    send_item(odd);
    send_item(edge_item(16'h0000));
    send_item(edge_item(16'hFFFF));
    send_item(edge_item(16'h8000));
    repeat (3) send_item(tick_item());
    send_item(edge_item(16'h0001));
    send_item(tick_item());
    send_item(edge_item(16'hFFFF));

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin recalc = 6'd35; limit = 8'd255; end
        1: begin recalc = 6'd0;  limit = 8'd0;   end
        2: begin recalc = 6'd63; limit = 8'd10;  end
        default: begin
          recalc = 6'($urandom_range(0, 35));
          limit  = 8'($urandom_range(1, 20));
        end
      endcase
      write_reg(REG_RECALC_TOOTH, {2'($urandom), recalc});
      write_reg(REG_OVERFLOW_LIMIT, limit);
      if (ph == 0) begin
        for (int i = 0; i < TEETH; i++) begin
          send_item(write_item(6'(i), ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom),
                               16'($urandom), ($urandom_range(0, 4) == 0) ? 8'h00
                               : 8'($urandom), 16'($urandom)));
        end
      end
      if (ph == 1) hold_token <= hold_token + 1;
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        // no sender gaps right after the hold-off starts, so the block backs up
        steady = (ph == 1) && (items_sent - phase_start < 100);
        pick   = $urandom_range(0, 99);
        if (pick < 55) begin
          base = ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 300000)
                                             : $urandom_range(40, 30000);
          // slow wheels cost several ticks per tooth, so keep them to one turn
          spin_wheel(base, (base > 65535) ? 1 : $urandom_range(1, 2),
                     $urandom_range(0, 5) == 0);
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 8)) send_item(rand_write_item());
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 14)) send_item(tick_item());
        end else begin
          repeat ($urandom_range(1, 10)) send_item(rand_item());
        end
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
